### rtl/rtcofs_pkg.sv
package rtcofs_pkg;

	// Register offsets inside the 128-byte window
	localparam logic [6:0] CLK_FIRST = 7'h10;
	localparam logic [6:0] CLK_LAST  = 7'h15;

	localparam logic [31:0] BASE_RESET = 32'h0000_D700;

	typedef enum logic [2:0] {
		SEL_SEC   = 3'd0,
		SEL_MIN   = 3'd1,
		SEL_HOUR  = 3'd2,
		SEL_DAY   = 3'd3,
		SEL_MONTH = 3'd4,
		SEL_YEAR  = 3'd5
	} clk_sel_t;

	typedef enum logic [1:0] {
		RD_NONE = 2'd0,
		RD_NV   = 2'd1,
		RD_CLK  = 2'd2
	} rd_kind_t;

	// Two BCD digits (bit 7 already masked) to binary, 0..85
	function automatic logic [6:0] bcd_in(input logic [6:0] v);
		logic [6:0] tens;
		tens = {4'b0, v[6:4]};
		return 7'(tens * 7'd10) + {3'b0, v[3:0]};
	endfunction

	// Binary 0..99 to two BCD digits; tens through reciprocal of 10
	function automatic logic [7:0] bcd_out(input logic [6:0] u);
		logic [13:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		prod = 14'(u) * 14'd103;
		tens = prod[13:10];
		ones = u - 7'(tens * 7'd10);
		return {tens, ones[3:0]};
	endfunction

	// Floored modulo 60 for values in -128..254
	function automatic logic [6:0] wrap60(input logic signed [9:0] v);
		logic [9:0] x;
		x = 10'(v + 10'sd180);
		if (x >= 10'd240) x = x - 10'd240;
		if (x >= 10'd120) x = x - 10'd120;
		if (x >= 10'd60)  x = x - 10'd60;
		return x[6:0];
	endfunction

	// Floored modulo 24 for values in -128..254
	function automatic logic [6:0] wrap24(input logic signed [9:0] v);
		logic [9:0] x;
		x = 10'(v + 10'sd144);
		if (x >= 10'd384) x = x - 10'd384;
		if (x >= 10'd192) x = x - 10'd192;
		if (x >= 10'd96)  x = x - 10'd96;
		if (x >= 10'd48)  x = x - 10'd48;
		if (x >= 10'd24)  x = x - 10'd24;
		return x[6:0];
	endfunction

	// Floored modulo 100 for values in -128..254
	function automatic logic [6:0] wrap100(input logic signed [9:0] v);
		logic [9:0] x;
		x = 10'(v + 10'sd200);
		if (x >= 10'd400) x = x - 10'd400;
		if (x >= 10'd200) x = x - 10'd200;
		if (x >= 10'd100) x = x - 10'd100;
		return x[6:0];
	endfunction

	function automatic logic [6:0] clamp(input logic signed [9:0] v,
			input logic [6:0] lo, input logic [6:0] hi);
		logic signed [9:0] slo;
		logic signed [9:0] shi;
		slo = signed'({3'b0, lo});
		shi = signed'({3'b0, hi});
		if (v < slo)
			return lo;
		else if (v > shi)
			return hi;
		else
			return v[6:0];
	endfunction

endpackage

### rtl/rtc_offset_registers_with_nvram.sv
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_write_en         cfg_write_data (base address)
// request   in         in_valid / in_stall  func, address, write_data, now_*
// result    out        out_valid/out_stall  claimed, read_data
//
// One request per clock while in_stall is low; each result is registered in stage 1, then in the output register.
// Stage 1 holds the decoded request, the byte-store read and the offset sum;
// the output register holds the normalized BCD byte.
// Reset clears the base address to 0xD700, all clock offsets and the
// per-byte valid bits of the store, so unwritten bytes read as zero.
// A stalled result holds; stage 1 still takes one more request behind it.
module rtc_offset_registers_with_nvram #(
	parameter int NV_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [31:0] cfg_write_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [31:0] address,
	input  logic [7:0]  write_data,
	input  logic [5:0]  now_second,
	input  logic [5:0]  now_minute,
	input  logic [4:0]  now_hour,
	input  logic [4:0]  now_day,
	input  logic [3:0]  now_month,
	input  logic [6:0]  now_year,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        claimed,
	output logic [7:0]  read_data
);

	localparam int AW = (NV_DEPTH > 1) ? $clog2(NV_DEPTH) : 1;

	// Configuration and clock offsets
	logic [31:0] base_q;
	logic [7:0]  sec_off_q, min_off_q, hour_off_q, day_off_q, mon_off_q, year_off_q;

	// Byte store and its valid bits
	logic [7:0] nv_mem [NV_DEPTH];
	logic       nv_vld_q [NV_DEPTH];

	// Stage 1
	logic                     valid_s1;
	logic                     claimed_s1;
	rtcofs_pkg::rd_kind_t     kind_s1;
	rtcofs_pkg::clk_sel_t     sel_s1;
	logic signed [9:0]        sum_s1;
	logic [7:0]               nv_data_s1;
	logic                     nv_ok_s1;

	// Output register
	logic       out_valid_q;
	logic       claimed_q;
	logic [7:0] read_data_q;

	// Request decode
	logic                 accept;
	logic                 out_ld;
	logic                 hit;
	logic [6:0]           reg_off;
	logic                 is_nv;
	logic                 is_clk;
	logic [AW-1:0]        nv_idx;
	rtcofs_pkg::clk_sel_t sel;
	logic [6:0]           field;
	logic [7:0]           cur_off;
	logic [6:0]           dec;
	logic [7:0]           new_off;
	logic signed [9:0]    sum;

	// Result logic
	logic [7:0] rd_val;

	// Advance the pipeline whenever the output register is free or drains
	assign out_ld   = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !out_ld;
	assign accept   = in_valid && !in_stall;

	assign hit     = (address[31:7] == base_q[31:7]) && (base_q[6:0] == 7'd0);
	assign reg_off = address[6:0];
	assign is_nv   = reg_off[6] && ({1'b0, reg_off[5:0]} < 7'(NV_DEPTH));
	assign is_clk  = (reg_off >= rtcofs_pkg::CLK_FIRST) &&
		(reg_off <= rtcofs_pkg::CLK_LAST);
	assign nv_idx  = reg_off[AW-1:0];
	assign sel     = rtcofs_pkg::clk_sel_t'(reg_off[2:0]);

	// Pick the time field and its stored offset for the addressed register
	always_comb begin
		unique case (sel)
			rtcofs_pkg::SEL_SEC: begin
				field   = {1'b0, now_second};
				cur_off = sec_off_q;
			end
			rtcofs_pkg::SEL_MIN: begin
				field   = {1'b0, now_minute};
				cur_off = min_off_q;
			end
			rtcofs_pkg::SEL_HOUR: begin
				field   = {2'b0, now_hour};
				cur_off = hour_off_q;
			end
			rtcofs_pkg::SEL_DAY: begin
				field   = {2'b0, now_day};
				cur_off = day_off_q;
			end
			rtcofs_pkg::SEL_MONTH: begin
				field   = {3'b0, now_month};
				cur_off = mon_off_q;
			end
			rtcofs_pkg::SEL_YEAR: begin
				field   = now_year;
				cur_off = year_off_q;
			end
			default: begin
				field   = 7'd0;
				cur_off = 8'd0;
			end
		endcase
	end

	// Write: decode BCD (for hour the decoded value is masked to 6 bits), keep the difference to now
	always_comb begin
		dec = rtcofs_pkg::bcd_in(write_data[6:0]);
		if (sel == rtcofs_pkg::SEL_HOUR)
			dec = dec & 7'h3F;
		new_off = 8'({1'b0, dec}) - 8'({1'b0, field});
	end

	// Read: time field plus signed offset, normalized in the next stage
	assign sum = signed'({3'b0, field}) + 10'(signed'(cur_off));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= rtcofs_pkg::BASE_RESET;
			sec_off_q  <= 8'd0;
			min_off_q  <= 8'd0;
			hour_off_q <= 8'd0;
			day_off_q  <= 8'd0;
			mon_off_q  <= 8'd0;
			year_off_q <= 8'd0;
		end else begin
			if (cfg_write_en)
				base_q <= cfg_write_data;
			if (accept && hit && is_clk && func) begin
				unique case (sel)
					rtcofs_pkg::SEL_SEC:   sec_off_q  <= new_off;
					rtcofs_pkg::SEL_MIN:   min_off_q  <= new_off;
					rtcofs_pkg::SEL_HOUR:  hour_off_q <= new_off;
					rtcofs_pkg::SEL_DAY:   day_off_q  <= new_off;
					rtcofs_pkg::SEL_MONTH: mon_off_q  <= new_off;
					rtcofs_pkg::SEL_YEAR:  year_off_q <= new_off;
					default: ;
				endcase
			end
		end
	end

	// Valid bits: set on first write so unwritten bytes read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NV_DEPTH; i++)
				nv_vld_q[i] <= 1'b0;
		end else if (accept && hit && is_nv && func) begin
			nv_vld_q[nv_idx] <= 1'b1;
		end
	end

	// Store write and registered read at the accept edge
	always_ff @(posedge clk) begin
		if (accept && hit && is_nv) begin
			if (func)
				nv_mem[nv_idx] <= write_data;
			nv_data_s1 <= nv_mem[nv_idx];
			nv_ok_s1   <= nv_vld_q[nv_idx];
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_ld) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			claimed_s1 <= hit;
			sel_s1     <= sel;
			sum_s1     <= sum;
			if (!hit || func)
				kind_s1 <= rtcofs_pkg::RD_NONE;
			else if (is_nv)
				kind_s1 <= rtcofs_pkg::RD_NV;
			else if (is_clk)
				kind_s1 <= rtcofs_pkg::RD_CLK;
			else
				kind_s1 <= rtcofs_pkg::RD_NONE;
		end
	end

	// Pick the stored byte (zero if unwritten), or normalize the clock value and convert to BCD
	always_comb begin
		unique case (kind_s1)
			rtcofs_pkg::RD_NV:
				rd_val = nv_ok_s1 ? nv_data_s1 : 8'd0;
			rtcofs_pkg::RD_CLK: begin
				unique case (sel_s1)
					rtcofs_pkg::SEL_SEC:
						rd_val = rtcofs_pkg::bcd_out(rtcofs_pkg::wrap60(sum_s1));
					rtcofs_pkg::SEL_MIN:
						rd_val = rtcofs_pkg::bcd_out(rtcofs_pkg::wrap60(sum_s1));
					rtcofs_pkg::SEL_HOUR:
						rd_val = rtcofs_pkg::bcd_out(rtcofs_pkg::wrap24(sum_s1)) | 8'h80;
					rtcofs_pkg::SEL_DAY:
						rd_val = rtcofs_pkg::bcd_out(
							rtcofs_pkg::clamp(sum_s1, 7'd1, 7'd31));
					rtcofs_pkg::SEL_MONTH:
						rd_val = rtcofs_pkg::bcd_out(
							rtcofs_pkg::clamp(sum_s1, 7'd1, 7'd12));
					rtcofs_pkg::SEL_YEAR:
						rd_val = rtcofs_pkg::bcd_out(rtcofs_pkg::wrap100(sum_s1));
					default:
						rd_val = 8'd0;
				endcase
			end
			default:
				rd_val = 8'd0;
		endcase
	end

	// Output register: load when free or when the current result drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld && valid_s1) begin
			claimed_q   <= claimed_s1;
			read_data_q <= rd_val;
		end
	end

	assign out_valid = out_valid_q;
	assign claimed   = claimed_q;
	assign read_data = read_data_q;

endmodule
